// File: rtl/nibp_pkg.sv
// ----------------------------------------------------------------------------
// nibp_pkg
// Shared types and constants for the nand indexed branch predictor.
// ----------------------------------------------------------------------------
package nibp_pkg;

    localparam int TABLE_ENTRIES_DEF = 2048;
    localparam int COUNTER_BITS_DEF  = 2;
    localparam int THREADS_DEF       = 4;
    localparam int INST_SHIFT_DEF    = 2;

    localparam int OP_W     = 3;
    localparam int THREAD_W = 2;
    localparam int ADDR_W   = 48;
    localparam int HIST_W   = 32;
    localparam int HB_W     = 6;

    localparam logic [HB_W-1:0] HIST_BITS_RESET = 6'd16;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP   = 3'd0,
        OP_UNCOND   = 3'd1,
        OP_UPDATE   = 3'd2,
        OP_SQUASH   = 3'd3,
        OP_BTB_MISS = 3'd4
    } t_op;

    typedef struct packed {
        logic                we;
        logic [THREAD_W-1:0] thread;
        t_op                 op;
        logic                bit_in;
        logic [HIST_W-1:0]   saved;
    } t_hist_cmd;

endpackage

// File: rtl/nibp_if.sv
// ----------------------------------------------------------------------------
// nibp channel interfaces
// Valid/ready channels for items, results and the history width register.
// ----------------------------------------------------------------------------
interface nibp_in_if
    import nibp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [THREAD_W-1:0] thread;
    logic [ADDR_W-1:0]   branch_addr;
    logic                taken;
    logic                was_squashed;
    logic [HIST_W-1:0]   saved_history;

    modport source (
        output valid, op, thread, branch_addr, taken, was_squashed, saved_history,
        input  ready
    );
    modport sink (
        input  valid, op, thread, branch_addr, taken, was_squashed, saved_history,
        output ready
    );
endinterface

interface nibp_out_if
    import nibp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              prediction;
    logic [HIST_W-1:0] history_snapshot;

    modport source (output valid, prediction, history_snapshot, input ready);
    modport sink   (input valid, prediction, history_snapshot, output ready);
endinterface

interface nibp_cfg_if
    import nibp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [HB_W-1:0] history_bits;

    modport source (output valid, history_bits, input ready);
    modport sink   (input valid, history_bits, output ready);
endinterface

// File: rtl/nibp_hist.sv
// ----------------------------------------------------------------------------
// nibp_hist
// Per-thread global history registers with masked shift and restore.
// ----------------------------------------------------------------------------
module nibp_hist
    import nibp_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [HB_W-1:0]     i_hist_bits,
    input  logic [THREAD_W-1:0] i_rd_thread,
    output logic [HIST_W-1:0]   o_rd_hist,
    input  t_hist_cmd           i_cmd
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;

    logic [HIST_W-1:0] r_hist [THREADS];
    logic [HIST_W-1:0] n_hist;
    logic [HIST_W-1:0] hist_mask;
    logic [HIST_W-1:0] cur;
    logic [HB_W-1:0]   nbits;
    logic              rd_ok;
    logic              wr_ok;

    assign rd_ok = ({{(32-THREAD_W){1'b0}}, i_rd_thread} < 32'(THREADS));
    assign wr_ok = ({{(32-THREAD_W){1'b0}}, i_cmd.thread} < 32'(THREADS));

    assign o_rd_hist = rd_ok ? r_hist[TW'(i_rd_thread)] : '0;
    assign cur       = wr_ok ? r_hist[TW'(i_cmd.thread)] : '0;

    assign nbits     = (i_hist_bits > HB_W'(HIST_W)) ? HB_W'(HIST_W) : i_hist_bits;
    assign hist_mask = (nbits == HB_W'(HIST_W)) ? '1
                     : ((HIST_W'(1) << nbits) - HIST_W'(1));

    always_comb begin
        case (i_cmd.op)
            OP_LOOKUP:   n_hist = {cur[HIST_W-2:0], i_cmd.bit_in};
            OP_UNCOND:   n_hist = {cur[HIST_W-2:0], 1'b1};
            OP_UPDATE:   n_hist = {i_cmd.saved[HIST_W-2:0], i_cmd.bit_in};
            OP_SQUASH:   n_hist = i_cmd.saved;
            OP_BTB_MISS: n_hist = {cur[HIST_W-1:1], 1'b0};
            default:     n_hist = cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < THREADS; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_cmd.we && wr_ok) begin
            r_hist[TW'(i_cmd.thread)] <= n_hist & hist_mask;
        end
    end

endmodule

// File: rtl/nand_indexed_branch_predictor.sv
// ----------------------------------------------------------------------------
// nand_indexed_branch_predictor
// Gshare-style predictor indexed by NOT(pc index AND history index).
// ----------------------------------------------------------------------------
// Each item passes through two steps: a read of the counter memory at the
// index formed from the address and the history, then, once the output
// register is free, an update of the counter and the thread history and a
// load of the result register. The next item is accepted only after that
// read-modify-write, so items never overlap. A finished result waits in the
// output register while the next item is taken. After reset a clearing pass
// writes zero to every counter, one entry per cycle, TABLE_ENTRIES entries
// (2048 by default); no items are accepted until it ends. The history width
// register may be written at any time the block is idle.
module nand_indexed_branch_predictor
    import nibp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
    parameter int THREADS       = THREADS_DEF,
    parameter int INST_SHIFT    = INST_SHIFT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nibp_in_if.sink    i_in,
    nibp_out_if.source o_out,
    nibp_cfg_if.sink   i_cfg
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [COUNTER_BITS-1:0] CTR_MAX  = '1;
    localparam logic [COUNTER_BITS-1:0] CTR_HALF =
        COUNTER_BITS'((1 << (COUNTER_BITS - 1)) - 1);

    logic [COUNTER_BITS-1:0] mem [TABLE_ENTRIES];

    logic [HB_W-1:0]         r_hist_bits;
    logic                    r_clr_busy;
    logic [IDX_W-1:0]        r_clr_idx;
    logic                    r_s1_valid;
    t_op                     r_op;
    logic [THREAD_W-1:0]     r_thread;
    logic                    r_ok;
    logic                    r_taken;
    logic                    r_squashed;
    logic [HIST_W-1:0]       r_saved;
    logic [HIST_W-1:0]       r_snap;
    logic [IDX_W-1:0]        r_idx;
    logic [COUNTER_BITS-1:0] r_rd_data;
    logic                    r_out_valid;
    logic                    r_out_pred;
    logic [HIST_W-1:0]       r_out_snap;

    logic                    accept;
    logic                    s1_fire;
    logic [HIST_W-1:0]       cur_hist;
    logic [HIST_W-1:0]       idx_hist;
    logic [IDX_W-1:0]        pc_idx;
    logic [IDX_W-1:0]        rd_idx;
    logic                    pred;
    logic [COUNTER_BITS-1:0] ctr_next;
    logic                    ctr_we;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wa;
    logic [COUNTER_BITS-1:0] mem_wd;
    logic                    n_out_pred;
    logic [HIST_W-1:0]       n_out_snap;
    t_hist_cmd               hist_cmd;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_clr_busy && !r_s1_valid;
    assign accept      = i_in.valid && i_in.ready;
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_out.ready);

    assign o_out.valid            = r_out_valid;
    assign o_out.prediction       = r_out_pred;
    assign o_out.history_snapshot = r_out_snap;

    nibp_hist #(
        .THREADS (THREADS)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hist_bits (r_hist_bits),
        .i_rd_thread (i_in.thread),
        .o_rd_hist   (cur_hist),
        .i_cmd       (hist_cmd)
    );

    // index: not (pc index and history index)
    assign pc_idx   = IDX_W'(i_in.branch_addr >> INST_SHIFT);
    assign idx_hist = (t_op'(i_in.op) == OP_UPDATE) ? i_in.saved_history : cur_hist;
    assign rd_idx   = ~(pc_idx & idx_hist[IDX_W-1:0]);

    assign pred = (r_rd_data > CTR_HALF);

    always_comb begin
        if (r_taken) begin
            ctr_next = (r_rd_data != CTR_MAX) ? r_rd_data + 1'b1 : r_rd_data;
        end else begin
            ctr_next = (r_rd_data != '0) ? r_rd_data - 1'b1 : r_rd_data;
        end
    end

    assign ctr_we = s1_fire && r_ok && (r_op == OP_UPDATE) && !r_squashed;

    always_comb begin
        n_out_pred      = 1'b0;
        n_out_snap      = '0;
        hist_cmd.we     = 1'b0;
        hist_cmd.thread = r_thread;
        hist_cmd.op     = r_op;
        hist_cmd.bit_in = r_taken;
        hist_cmd.saved  = r_saved;
        if (r_ok) begin
            case (r_op)
                OP_LOOKUP: begin
                    n_out_pred      = pred;
                    n_out_snap      = r_snap;
                    hist_cmd.bit_in = pred;
                    hist_cmd.we     = s1_fire;
                end
                OP_UNCOND: begin
                    n_out_pred  = 1'b1;
                    n_out_snap  = r_snap;
                    hist_cmd.we = s1_fire;
                end
                OP_UPDATE: begin
                    hist_cmd.we = s1_fire && r_squashed;
                end
                OP_SQUASH, OP_BTB_MISS: begin
                    hist_cmd.we = s1_fire;
                end
                default: begin
                    hist_cmd.we = 1'b0;
                end
            endcase
        end
    end

    assign mem_we = r_clr_busy || ctr_we;
    assign mem_wa = r_clr_busy ? r_clr_idx : r_idx;
    assign mem_wd = r_clr_busy ? '0 : ctr_next;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rd_data <= mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_bits <= HIST_BITS_RESET;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_hist_bits <= i_cfg.history_bits;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= t_op'(i_in.op);
            r_thread   <= i_in.thread;
            r_ok       <= ({{(32-THREAD_W){1'b0}}, i_in.thread} < 32'(THREADS));
            r_taken    <= i_in.taken;
            r_squashed <= i_in.was_squashed;
            r_saved    <= i_in.saved_history;
            r_snap     <= cur_hist;
            r_idx      <= rd_idx;
        end
        if (s1_fire) begin
            r_out_pred <= n_out_pred;
            r_out_snap <= n_out_snap;
        end
    end

endmodule

// File: rtl/nibp_checker.sv
// ----------------------------------------------------------------------------
// nibp_checker
// Port-level checks on the predictor, bound to the top level.
// ----------------------------------------------------------------------------
module nibp_checker
    import nibp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_pred,
    input logic [HIST_W-1:0] i_out_snap
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_pred) && $stable(i_out_snap)))
        else $error("result changed while stalled");

    // one item in flight
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("item accepted while previous item in flight");

    // every accepted item is followed by a valid result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 i_out_valid)
        else $error("no result after accepted item");

    // counter clear runs after reset
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("item accepted during counter clear");

endmodule

bind nand_indexed_branch_predictor nibp_checker u_nibp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pred  (o_out.prediction),
    .i_out_snap  (o_out.history_snapshot)
);

// File: tb/nand_indexed_branch_predictor_tb.sv
// ----------------------------------------------------------------------------
// nand_indexed_branch_predictor_tb
// Self-checking testbench for the nand indexed branch predictor. A short
// stimulus table covers the field extremes, every op, saturation, history
// restore and reserved ops. Random branch traffic follows: lookups and
// unconditionals feed their snapshots back into later updates and squashes.
// Each phase sets a history width and one of four patterns of sender idling
// and receiver stalls; results are checked against pinned row values or an
// in-bench model of the per-thread history and the shared counter table.
// ----------------------------------------------------------------------------
module nand_indexed_branch_predictor_tb;
    import nibp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W          = $clog2(TABLE_ENTRIES_DEF);
    localparam int CTR_MAX        = (1 << COUNTER_BITS_DEF) - 1;
    localparam int CTR_HALF       = (1 << (COUNTER_BITS_DEF - 1)) - 1;
    localparam int WATCHDOG_LIMIT = 8 * TABLE_ENTRIES_DEF;
    localparam int POOL_N         = 16;
    localparam int PHASES         = 8;
    localparam int DIRECTED_N     = 25;
    localparam int WIDTH_RANDOM   = -1;

    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [THREAD_W-1:0] thread;
        logic [ADDR_W-1:0]   addr;
        logic                taken;
        logic                squashed;
        logic [HIST_W-1:0]   saved;
    } t_branch_item;

    typedef struct packed {
        logic              pred;
        logic [HIST_W-1:0] snap;
    } t_branch_result;

    typedef struct packed {
        t_branch_item   item;
        logic           pinned;
        t_branch_result want;
    } t_stim_row;

    logic clk;
    logic rst_n;

    nibp_in_if  in_ch ();
    nibp_out_if out_ch ();
    nibp_cfg_if cfg_ch ();

    nand_indexed_branch_predictor dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    logic [HIST_W-1:0]  thread_history [THREADS_DEF];
    logic [COUNTER_BITS_DEF-1:0] counter_table [TABLE_ENTRIES_DEF];
    logic [HB_W-1:0]    hist_bits;

    t_branch_result     pending_results [$];
    t_stim_row          stim_table [DIRECTED_N];

    logic [ADDR_W-1:0]  addr_pool [POOL_N];
    logic [ADDR_W-1:0]  snap_addr [POOL_N];
    logic [HIST_W-1:0]  snap_hist [POOL_N];
    logic [THREAD_W-1:0] snap_thread [POOL_N];
    int                 snap_fill;
    int                 snap_wr;

    logic               pin_row;
    t_branch_result     pin_want;

    int idle_pct;
    int stall_pct;
    int mismatch_count;
    int items_sent;
    int results_seen;
    int taken_predictions;
    int cfg_writes;
    int quiet_cycles;

    int phase_width [PHASES] = '{16, 32, 1, 0, 63, 11, WIDTH_RANDOM, 40};
    int phase_idle  [PHASES] = '{0, 58, 0, 12, 0, 58, 0, 12};
    int phase_stall [PHASES] = '{0, 0, 58, 12, 0, 0, 58, 12};
    int phase_items [PHASES] = '{100, 86, 86, 86, 86, 86, 86, 86};

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [HIST_W-1:0] history_mask();
        int n;
        n = (hist_bits > 6'd32) ? 32 : int'(hist_bits);
        return HIST_W'((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [IDX_W-1:0] counter_slot(logic [ADDR_W-1:0] addr,
                                                      logic [HIST_W-1:0] hist);
        logic [ADDR_W-1:0] pc;
        pc = addr >> INST_SHIFT_DEF;
        return ~(pc[IDX_W-1:0] & hist[IDX_W-1:0]);
    endfunction

    function automatic t_branch_result predict_branch(t_branch_item it);
        t_branch_result r;
        logic [IDX_W-1:0] slot;
        logic [COUNTER_BITS_DEF-1:0] c;
        logic [HIST_W-1:0] mask;
        r = '0;
        mask = history_mask();
        case (it.op)
            OP_LOOKUP: begin
                slot = counter_slot(it.addr, thread_history[it.thread]);
                c = counter_table[slot];
                r.pred = (int'(c) > CTR_HALF);
                r.snap = thread_history[it.thread];
                thread_history[it.thread] = ((r.snap << 1) | HIST_W'(r.pred)) & mask;
            end
            OP_UNCOND: begin
                r.pred = 1'b1;
                r.snap = thread_history[it.thread];
                thread_history[it.thread] = ((r.snap << 1) | 32'd1) & mask;
            end
            OP_UPDATE: begin
                if (it.squashed) begin
                    thread_history[it.thread] = ((it.saved << 1) | HIST_W'(it.taken)) & mask;
                end else begin
                    slot = counter_slot(it.addr, it.saved);
                    c = counter_table[slot];
                    if (it.taken && int'(c) < CTR_MAX) begin
                        c = c + 1'b1;
                    end else if (!it.taken && c != '0) begin
                        c = c - 1'b1;
                    end
                    counter_table[slot] = c;
                end
            end
            OP_SQUASH: begin
                thread_history[it.thread] = it.saved & mask;
            end
            OP_BTB_MISS: begin
                thread_history[it.thread] = thread_history[it.thread] & mask & ~32'd1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_stim_row row(logic [OP_W-1:0] op, logic [THREAD_W-1:0] thread,
                                      logic [ADDR_W-1:0] addr, logic taken, logic squashed,
                                      logic [HIST_W-1:0] saved, logic pinned, logic pred,
                                      logic [HIST_W-1:0] snap);
        t_stim_row s;
        s.item = '{op, thread, addr, taken, squashed, saved};
        s.pinned = pinned;
        s.want = '{pred, snap};
        return s;
    endfunction

    function automatic t_branch_item random_branch();
        t_branch_item it;
        int k;
        int j;
        it.op = OP_W'($urandom_range(0, 7));
        it.thread = THREAD_W'($urandom_range(0, THREADS_DEF - 1));
        it.addr = ADDR_W'({$urandom, $urandom});
        it.taken = 1'($urandom);
        it.squashed = 1'($urandom);
        it.saved = $urandom;
        if ($urandom_range(0, 9) != 0) begin
            it.addr = addr_pool[$urandom_range(0, POOL_N - 1)];
        end
        j = (snap_fill == 0) ? -1 : int'($urandom_range(0, snap_fill - 1));
        k = $urandom_range(0, 99);
        if (k < 36) begin
            it.op = OP_LOOKUP;
        end else if (k < 44) begin
            it.op = OP_UNCOND;
        end else if (k < 79) begin
            it.op = OP_UPDATE;
            it.squashed = (k >= 74);
            if (j >= 0) begin
                it.addr = snap_addr[j];
                it.saved = snap_hist[j];
                it.thread = snap_thread[j];
            end
            if (!it.squashed) begin
                it.taken = ($urandom_range(0, 99) < (it.addr[INST_SHIFT_DEF] ? 80 : 25));
            end
        end else if (k < 86) begin
            it.op = OP_SQUASH;
            if (j >= 0) begin
                it.saved = snap_hist[j];
                it.thread = snap_thread[j];
            end
        end else if (k < 91) begin
            it.op = OP_BTB_MISS;
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [HIST_W-1:0] want,
                                   logic [HIST_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    task automatic send_item(t_branch_item it, logic pinned, t_branch_result want);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= it.op;
        in_ch.thread        <= it.thread;
        in_ch.branch_addr   <= it.addr;
        in_ch.taken         <= it.taken;
        in_ch.was_squashed  <= it.squashed;
        in_ch.saved_history <= it.saved;
        pin_row             <= pinned;
        pin_want            <= want;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_hist_bits(logic [HB_W-1:0] width);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.history_bits <= width;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        t_branch_item it;
        t_branch_result r;
        t_branch_result want;
        logic moved;
        moved = 1'b0;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, out_ch.history_snapshot);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.prediction !== want.pred) begin
                        report_mismatch("prediction", HIST_W'(want.pred),
                                        HIST_W'(out_ch.prediction));
                    end
                    if (out_ch.history_snapshot !== want.snap) begin
                        report_mismatch("history_snapshot", want.snap,
                                        out_ch.history_snapshot);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                items_sent++;
                it = '{in_ch.op, in_ch.thread, in_ch.branch_addr, in_ch.taken,
                       in_ch.was_squashed, in_ch.saved_history};
                r = predict_branch(it);
                if (it.op == OP_LOOKUP && r.pred) begin
                    taken_predictions++;
                end
                if (it.op == OP_LOOKUP || it.op == OP_UNCOND) begin
                    snap_addr[snap_wr] = it.addr;
                    snap_hist[snap_wr] = r.snap;
                    snap_thread[snap_wr] = it.thread;
                    snap_wr = (snap_wr + 1) % POOL_N;
                    if (snap_fill < POOL_N) begin
                        snap_fill++;
                    end
                end
                pending_results.push_back(pin_row ? pin_want : r);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                cfg_writes++;
                hist_bits = cfg_ch.history_bits;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int width;
        t_branch_result none;
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.thread = '0;
        in_ch.branch_addr = '0;
        in_ch.taken = 1'b0;
        in_ch.was_squashed = 1'b0;
        in_ch.saved_history = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.history_bits = '0;
        pin_row = 1'b0;
        pin_want = '0;
        none = '0;
        idle_pct = 0;
        stall_pct = 0;
        mismatch_count = 0;
        items_sent = 0;
        results_seen = 0;
        taken_predictions = 0;
        cfg_writes = 0;
        quiet_cycles = 0;
        snap_fill = 0;
        snap_wr = 0;
        hist_bits = HIST_BITS_RESET;
        for (int i = 0; i < THREADS_DEF; i++) thread_history[i] = '0;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++) counter_table[i] = '0;
        for (int i = 0; i < POOL_N; i++) addr_pool[i] = ADDR_W'({$urandom, $urandom});

        stim_table[0]  = row(OP_LOOKUP, 0, '0, 0, 0, '0, 1, 0, 32'h0);
        stim_table[1]  = row(OP_UNCOND, 0, '0, 0, 0, '0, 1, 1, 32'h0);
        stim_table[2]  = row(OP_UNCOND, 0, '0, 0, 0, '0, 1, 1, 32'h1);
        stim_table[3]  = row(OP_LOOKUP, 0, '1, 1, 1, '1, 1, 0, 32'h3);
        stim_table[4]  = row(OP_UPDATE, 1, '1, 1, 0, '0, 1, 0, 32'h0);
        stim_table[5]  = row(OP_UPDATE, 1, '1, 1, 0, '0, 1, 0, 32'h0);
        stim_table[6]  = row(OP_UPDATE, 1, '1, 1, 0, '0, 1, 0, 32'h0);
        stim_table[7]  = row(OP_UPDATE, 1, '1, 1, 0, '0, 1, 0, 32'h0);
        stim_table[8]  = row(OP_LOOKUP, 1, '1, 0, 0, '0, 1, 1, 32'h0);
        stim_table[9]  = row(OP_UPDATE, 1, '1, 0, 0, '0, 1, 0, 32'h0);
        stim_table[10] = row(OP_UPDATE, 1, '1, 0, 0, '0, 1, 0, 32'h0);
        stim_table[11] = row(OP_UPDATE, 1, '1, 0, 0, '0, 1, 0, 32'h0);
        stim_table[12] = row(OP_UPDATE, 1, '1, 0, 0, '0, 1, 0, 32'h0);
        stim_table[13] = row(OP_LOOKUP, 1, '1, 0, 0, '0, 0, 0, 32'h0);
        stim_table[14] = row(OP_SQUASH, 2, '0, 0, 0, '1, 1, 0, 32'h0);
        stim_table[15] = row(OP_UNCOND, 2, '0, 0, 0, '0, 1, 1, 32'h0000_ffff);
        stim_table[16] = row(OP_BTB_MISS, 2, '0, 0, 0, '0, 1, 0, 32'h0);
        stim_table[17] = row(OP_UNCOND, 2, '0, 0, 0, '0, 1, 1, 32'h0000_fffe);
        stim_table[18] = row(OP_UPDATE, 3, '0, 0, 1, '1, 1, 0, 32'h0);
        stim_table[19] = row(OP_LOOKUP, 3, 48'h8000_0000_0000, 0, 0, '0, 0, 0, 32'h0);
        stim_table[20] = row(OP_RSVD_A, 0, '1, 1, 1, '1, 1, 0, 32'h0);
        stim_table[21] = row(OP_RSVD_B, 3, '1, 1, 0, '1, 1, 0, 32'h0);
        stim_table[22] = row(OP_RSVD_C, 1, '0, 0, 1, '0, 1, 0, 32'h0);
        stim_table[23] = row(OP_UPDATE, 0, '0, 1, 0, '1, 0, 0, 32'h0);
        stim_table[24] = row(OP_LOOKUP, 2, '0, 0, 0, '0, 0, 0, 32'h0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            drain();
            width = (phase_width[p] == WIDTH_RANDOM) ? int'($urandom_range(1, 32))
                                                     : phase_width[p];
            write_hist_bits(HB_W'(width));
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            if (p == 0) begin
                for (int i = 0; i < DIRECTED_N; i++) begin
                    send_item(stim_table[i].item, stim_table[i].pinned, stim_table[i].want);
                end
            end
            for (int i = 0; i < phase_items[p]; i++) begin
                send_item(random_branch(), 1'b0, none);
            end
        end
        drain();
        repeat (8) @(posedge clk);

        if (pending_results.size() != 0) begin
            report_mismatch("results never arrived", '0, HIST_W'(pending_results.size()));
        end
        $display("covered %0d items and %0d results over %0d history widths",
                 items_sent, results_seen, cfg_writes);
        $display("lookups predicted taken %0d times, mismatches %0d",
                 taken_predictions, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/nibp_pkg.sv
rtl/nibp_if.sv
rtl/nibp_hist.sv
rtl/nand_indexed_branch_predictor.sv
rtl/nibp_checker.sv
tb/nand_indexed_branch_predictor_tb.sv
